// File: rtl/core/agd_pkg.sv
// Shared types, widths and constants for the accelerometer gesture detector.
// Used by every module under rtl/core; depends on nothing.
package agd_pkg;

  localparam int HISTORY_DEPTH   = 10;
  localparam int LANES           = HISTORY_DEPTH - 1;
  localparam int CNT_W           = $clog2(HISTORY_DEPTH);

  localparam int RAW_W           = 10;
  localparam int OFS_W           = 11;
  localparam int LVL_W           = 11;
  localparam int FLIP_W          = 10;
  localparam int AX_W            = 12;
  localparam int SQ_W            = 22;
  localparam int SUM_W           = 24;
  localparam int ENERGY_W        = 22;
  localparam int STEPS_W         = 4;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  localparam int SHAKE_MIN_STEPS = 5;
  localparam int STEPS_MAX       = 15;

  localparam int SHAKE_LEVEL_RST = 400;
  localparam int TAP_LOW_RST     = 600;
  localparam int TAP_HIGH_RST    = 1000;
  localparam int FLIP_LEVEL_RST  = 200;
  localparam int STEP_LEVEL_RST  = 200;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  typedef enum logic [2:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_OFFSET_Z    = 3'd2,
    REG_SHAKE_LEVEL = 3'd3,
    REG_TAP_LOW     = 3'd4,
    REG_TAP_HIGH    = 3'd5,
    REG_FLIP_LEVEL  = 3'd6,
    REG_STEP_LEVEL  = 3'd7
  } reg_idx_e;

  // squared magnitude thresholds
  typedef struct packed {
    logic [SQ_W-1:0] shake_sq;
    logic [SQ_W-1:0] tap_lo_sq;
    logic [SQ_W-1:0] tap_hi_sq;
  } thr_t;

  // second stage word handed to the merge stage
  typedef struct packed {
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
    logic            flip;
  } s2_t;

  function automatic logic [SQ_W-1:0] axis_sq(logic signed [AX_W-1:0] a);
    logic signed [2*AX_W-1:0] p;
    p = a * a;
    return p[SQ_W-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] level_sq(logic [LVL_W-1:0] v);
    logic [2*LVL_W-1:0] p;
    p = v * v;
    return p[SQ_W-1:0];
  endfunction

endpackage

// File: rtl/core/accel_gesture_detector_top.sv
// Accelerometer gesture detector: shake, tap and flip on one 3-axis sample.
// Holds config registers, X history, the step lanes and the merge stage.
// Depends on agd_pkg, agd_step_lane and agd_merge.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one raw X/Y/Z word.
//   Output channel (out_valid_o/out_ready_i) returns one result word per
//   input word: shake, tap, flip, large_steps and saturated energy.
//   Write registers over APB only while idle; the block does not enforce it.
// Timing:
//   Three register stages: offset correction and window capture, then the
//   step lanes with the axis squares and flip test, then the merge stage.
//   One word per cycle is sustained while out_ready_i is high; that is set by
//   the three-stage pipeline, each stage advancing whenever the stage after
//   it is free. Threshold squares are registered from the level registers
//   and follow a register write in the next cycle.
// Reset: registers return to their defaults, X history and previous Z
//   clear to zero, and every stage empties.
// Stall:
//   A held result keeps its value; earlier stages keep filling bubbles, and
//   in_ready_o drops once all three stages hold words.
module accel_gesture_detector_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic         [agd_pkg::ADDR_W-1:0]   paddr,
  input  logic         [agd_pkg::DATA_W-1:0]   pwdata,
  output logic         [agd_pkg::DATA_W-1:0]   prdata,
  output logic                                 pready,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed  [agd_pkg::RAW_W-1:0]    raw_x_i,
  input  logic signed  [agd_pkg::RAW_W-1:0]    raw_y_i,
  input  logic signed  [agd_pkg::RAW_W-1:0]    raw_z_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 shake_o,
  output logic                                 tap_o,
  output logic                                 flip_o,
  output logic         [agd_pkg::STEPS_W-1:0]  large_steps_o,
  output logic         [agd_pkg::ENERGY_W-1:0] energy_o
);

  localparam int AX_W  = agd_pkg::AX_W;
  localparam int LANES = agd_pkg::LANES;

  // ---------------- configuration registers ----------------
  logic signed [agd_pkg::OFS_W-1:0]  offset_x_q, offset_y_q, offset_z_q;
  logic        [agd_pkg::LVL_W-1:0]  shake_level_q, tap_low_q, tap_high_q, step_level_q;
  logic        [agd_pkg::FLIP_W-1:0] flip_level_q;
  logic                              cfg_wr;
  agd_pkg::reg_idx_e                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = agd_pkg::reg_idx_e'(paddr[agd_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q    <= '0;
      offset_y_q    <= '0;
      offset_z_q    <= '0;
      shake_level_q <= agd_pkg::LVL_W'(agd_pkg::SHAKE_LEVEL_RST);
      tap_low_q     <= agd_pkg::LVL_W'(agd_pkg::TAP_LOW_RST);
      tap_high_q    <= agd_pkg::LVL_W'(agd_pkg::TAP_HIGH_RST);
      flip_level_q  <= agd_pkg::FLIP_W'(agd_pkg::FLIP_LEVEL_RST);
      step_level_q  <= agd_pkg::LVL_W'(agd_pkg::STEP_LEVEL_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        agd_pkg::REG_OFFSET_X:    offset_x_q    <= pwdata[agd_pkg::OFS_W-1:0];
        agd_pkg::REG_OFFSET_Y:    offset_y_q    <= pwdata[agd_pkg::OFS_W-1:0];
        agd_pkg::REG_OFFSET_Z:    offset_z_q    <= pwdata[agd_pkg::OFS_W-1:0];
        agd_pkg::REG_SHAKE_LEVEL: shake_level_q <= pwdata[agd_pkg::LVL_W-1:0];
        agd_pkg::REG_TAP_LOW:     tap_low_q     <= pwdata[agd_pkg::LVL_W-1:0];
        agd_pkg::REG_TAP_HIGH:    tap_high_q    <= pwdata[agd_pkg::LVL_W-1:0];
        agd_pkg::REG_FLIP_LEVEL:  flip_level_q  <= pwdata[agd_pkg::FLIP_W-1:0];
        agd_pkg::REG_STEP_LEVEL:  step_level_q  <= pwdata[agd_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      agd_pkg::REG_OFFSET_X:    prdata = agd_pkg::DATA_W'(offset_x_q);
      agd_pkg::REG_OFFSET_Y:    prdata = agd_pkg::DATA_W'(offset_y_q);
      agd_pkg::REG_OFFSET_Z:    prdata = agd_pkg::DATA_W'(offset_z_q);
      agd_pkg::REG_SHAKE_LEVEL: prdata = agd_pkg::DATA_W'(shake_level_q);
      agd_pkg::REG_TAP_LOW:     prdata = agd_pkg::DATA_W'(tap_low_q);
      agd_pkg::REG_TAP_HIGH:    prdata = agd_pkg::DATA_W'(tap_high_q);
      agd_pkg::REG_FLIP_LEVEL:  prdata = agd_pkg::DATA_W'(flip_level_q);
      agd_pkg::REG_STEP_LEVEL:  prdata = agd_pkg::DATA_W'(step_level_q);
      default:                  prdata = '0;
    endcase
  end

  // threshold squares, registered from the level registers
  agd_pkg::thr_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.shake_sq  <= agd_pkg::SQ_W'(agd_pkg::SHAKE_LEVEL_RST * agd_pkg::SHAKE_LEVEL_RST);
      thr_q.tap_lo_sq <= agd_pkg::SQ_W'(agd_pkg::TAP_LOW_RST * agd_pkg::TAP_LOW_RST);
      thr_q.tap_hi_sq <= agd_pkg::SQ_W'(agd_pkg::TAP_HIGH_RST * agd_pkg::TAP_HIGH_RST);
    end else begin
      thr_q.shake_sq  <= agd_pkg::level_sq(shake_level_q);
      thr_q.tap_lo_sq <= agd_pkg::level_sq(tap_low_q);
      thr_q.tap_hi_sq <= agd_pkg::level_sq(tap_high_q);
    end
  end

  // ---------------- stage 1: correction and window capture ----------------
  logic                   en1, en2, adv_out, accept;
  logic signed [AX_W-1:0] cx_d, cy_d, cz_d;
  logic signed [AX_W-1:0] hist_q [LANES];
  logic signed [AX_W-1:0] prev_z_q;
  logic signed [AX_W-1:0] win_q  [LANES+1];
  logic signed [AX_W-1:0] cy1_q, cz1_q, pz1_q;
  logic                   v1_q, v2_q;

  assign cx_d = AX_W'(raw_x_i) - AX_W'(offset_x_q);
  assign cy_d = AX_W'(raw_y_i) - AX_W'(offset_y_q);
  assign cz_d = AX_W'(raw_z_i) - AX_W'(offset_z_q);

  assign en2        = !v2_q || adv_out;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        hist_q[i] <= '0;
      end
      prev_z_q <= '0;
    end else if (accept) begin
      for (int i = 0; i < LANES - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[LANES-1] <= cx_d;
      prev_z_q        <= cz_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < LANES; i++) begin
        win_q[i] <= hist_q[i];
      end
      win_q[LANES] <= cx_d;
      cy1_q        <= cy_d;
      cz1_q        <= cz_d;
      pz1_q        <= prev_z_q;
    end
  end

  // ---------------- stage 2: step lanes, squares, flip ----------------
  logic                   load2;
  logic [LANES-1:0]       flags;
  logic signed [AX_W-1:0] f_pos, f_neg;
  logic                   flip_d;
  agd_pkg::s2_t           s2_q;

  assign load2 = en2 && v1_q;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    agd_step_lane u_lane (
      .clk_i        (clk_i),
      .load_i       (load2),
      .newer_i      (win_q[g+1]),
      .older_i      (win_q[g]),
      .step_level_i (step_level_q),
      .flag_o       (flags[g])
    );
  end

  always_comb begin
    f_pos  = signed'(AX_W'(flip_level_q));
    f_neg  = -f_pos;
    flip_d = (pz1_q != '0) &&
             (((pz1_q > f_pos) && (cz1_q < f_neg)) ||
              ((pz1_q < f_neg) && (cz1_q > f_pos)));
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      s2_q.sq_x <= agd_pkg::axis_sq(win_q[LANES]);
      s2_q.sq_y <= agd_pkg::axis_sq(cy1_q);
      s2_q.sq_z <= agd_pkg::axis_sq(cz1_q);
      s2_q.flip <= flip_d;
    end
  end

  // ---------------- stage 3: merge and output word ----------------
  agd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v2_q),
    .flags_i       (flags),
    .s2_i          (s2_q),
    .thr_i         (thr_q),
    .adv_o         (adv_out),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .shake_o       (shake_o),
    .tap_o         (tap_o),
    .flip_o        (flip_o),
    .large_steps_o (large_steps_o),
    .energy_o      (energy_o)
  );

endmodule

// File: rtl/core/agd_step_lane.sv
// One X step lane: registered flag for |newer - older| > step level.
// Depends on agd_pkg.
module agd_step_lane (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic signed [agd_pkg::AX_W-1:0]   newer_i,
  input  logic signed [agd_pkg::AX_W-1:0]   older_i,
  input  logic        [agd_pkg::LVL_W-1:0]  step_level_i,
  output logic                              flag_o
);

  logic signed [agd_pkg::AX_W:0] diff;
  logic        [agd_pkg::AX_W:0] mag;
  logic                          flag_d;
  logic                          flag_q;

  always_comb begin
    diff   = (agd_pkg::AX_W+1)'(newer_i) - (agd_pkg::AX_W+1)'(older_i);
    mag    = diff[agd_pkg::AX_W] ? unsigned'(-diff) : unsigned'(diff);
    flag_d = mag > (agd_pkg::AX_W+1)'(step_level_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule

// File: rtl/core/agd_merge.sv
// Merge stage: counts lane flags, sums axis squares, applies thresholds,
// and holds the result word until taken. Depends on agd_pkg.
module agd_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic         [agd_pkg::LANES-1:0]   flags_i,
  input  agd_pkg::s2_t                        s2_i,
  input  agd_pkg::thr_t                       thr_i,
  output logic                                adv_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                shake_o,
  output logic                                tap_o,
  output logic                                flip_o,
  output logic         [agd_pkg::STEPS_W-1:0] large_steps_o,
  output logic         [agd_pkg::ENERGY_W-1:0] energy_o
);

  logic [agd_pkg::CNT_W-1:0]    cnt;
  logic [agd_pkg::SUM_W-1:0]    sum;
  logic [agd_pkg::STEPS_W-1:0]  steps_d;
  logic [agd_pkg::ENERGY_W-1:0] energy_d;
  logic                         shake_d;
  logic                         tap_d;

  logic                         valid_q;
  logic                         shake_q;
  logic                         tap_q;
  logic                         flip_q;
  logic [agd_pkg::STEPS_W-1:0]  steps_q;
  logic [agd_pkg::ENERGY_W-1:0] energy_q;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < agd_pkg::LANES; i++) begin
      cnt = cnt + agd_pkg::CNT_W'(flags_i[i]);
    end
    if (int'(cnt) > agd_pkg::STEPS_MAX) begin
      steps_d = agd_pkg::STEPS_W'(agd_pkg::STEPS_MAX);
    end else begin
      steps_d = agd_pkg::STEPS_W'(cnt);
    end

    sum = agd_pkg::SUM_W'(s2_i.sq_x) + agd_pkg::SUM_W'(s2_i.sq_y)
        + agd_pkg::SUM_W'(s2_i.sq_z);
    // compares use the full sum; only the reported word saturates
    if (sum > agd_pkg::SUM_W'(agd_pkg::ENERGY_MAX)) begin
      energy_d = agd_pkg::ENERGY_MAX;
    end else begin
      energy_d = sum[agd_pkg::ENERGY_W-1:0];
    end

    shake_d = (sum > agd_pkg::SUM_W'(thr_i.shake_sq)) &&
              (int'(cnt) >= agd_pkg::SHAKE_MIN_STEPS);
    tap_d   = (sum > agd_pkg::SUM_W'(thr_i.tap_lo_sq)) &&
              (sum < agd_pkg::SUM_W'(thr_i.tap_hi_sq));
  end

  assign adv_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      shake_q  <= shake_d;
      tap_q    <= tap_d;
      flip_q   <= s2_i.flip;
      steps_q  <= steps_d;
      energy_q <= energy_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign shake_o       = shake_q;
  assign tap_o         = tap_q;
  assign flip_o        = flip_q;
  assign large_steps_o = steps_q;
  assign energy_o      = energy_q;

endmodule

// File: rtl/core/agd_checker.sv
// Port-level checks for the gesture detector, bound to the top level.
// Depends on agd_pkg and accel_gesture_detector_top.
module agd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 shake_o,
  input logic                                 tap_o,
  input logic                                 flip_o,
  input logic         [agd_pkg::STEPS_W-1:0]  large_steps_o,
  input logic         [agd_pkg::ENERGY_W-1:0] energy_o
);

  // a held word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a held word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(energy_o) && $stable(large_steps_o) && $stable(shake_o) &&
      $stable(tap_o) && $stable(flip_o))
    else $error("result word changed while stalled");

  // shake needs enough large steps
  a_shake_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shake_o |->
      large_steps_o >= agd_pkg::STEPS_W'(agd_pkg::SHAKE_MIN_STEPS))
    else $error("shake reported with too few steps");

  // shake and tap both need nonzero energy
  a_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (shake_o || tap_o) |-> energy_o != '0)
    else $error("gesture reported with zero energy");

endmodule

bind accel_gesture_detector_top agd_checker u_agd_checker (.*);
